// ----- hw/rtl/ped_pkg.sv -----
// Package for the percent-escape decoder: payload and queue-entry types,
// character constants and the digit classification function.
// Depends on nothing; every module of the decoder uses it.
package ped_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_LA      = 8'h61;
    localparam logic [7:0] CHAR_LZ      = 8'h7a;
    localparam logic [7:0] CHAR_UA      = 8'h41;
    localparam logic [7:0] CHAR_UZ      = 8'h5a;
    localparam logic [5:0] LETTER_BASE  = 6'd10;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ped_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       syntax_error;
    } ped_out_t;

    // One queue entry: the results caused by one input transfer.
    typedef struct packed {
        logic     two;
        ped_out_t r0;
        ped_out_t r1;
    } ped_cmd_t;

    typedef struct packed {
        logic     valid;
        ped_cmd_t cmd;
    } ped_qhead_t;

    typedef struct packed {
        logic     ok;
        logic [5:0] val;
    } ped_digit_t;

    function automatic ped_digit_t digit_value(input logic [7:0] c);
        ped_digit_t d;
        d.ok  = 1'b1;
        d.val = 6'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d.val = 6'(c - CHAR_0);
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            d.val = LETTER_BASE + 6'(c - CHAR_LA);
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            d.val = LETTER_BASE + 6'(c - CHAR_UA);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/percent_escape_decoder_top.sv -----
// Percent-escape decoder, top level. A result passes through the result queue
// and then the output register before it appears at the output.
// Throughput: one input byte per cycle while item_stall is low; a key end that
// gives two results sends them as two output transfers, buffered by the four-entry result queue.
// Reset (rst_n, asynchronous, active low) returns the decoder to plain text.
// Depends on ped_pkg, ped_front, ped_queue and ped_back.
module percent_escape_decoder_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ped_pkg::ped_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output ped_pkg::ped_out_t result
);

    logic                accept;
    logic                push;
    logic                pop;
    logic                full;
    ped_pkg::ped_cmd_t   cmd;
    ped_pkg::ped_qhead_t head;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    ped_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .cmd    (cmd)
    );

    ped_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .cmd   (cmd),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    ped_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- hw/rtl/ped_front.sv -----
// Front part of the percent-escape decoder: tracks the escape phase and
// turns each input transfer into no queue entry or an entry of one or two results.
// Depends on ped_pkg.
module ped_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ped_pkg::ped_in_t  item,
    output logic              push,
    output ped_pkg::ped_cmd_t cmd
);

    typedef enum logic [1:0]
    {
        PH_PLAIN = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIG   = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       disc_reg, disc_next;

    ped_pkg::ped_digit_t hi, lo;

    assign hi = ped_pkg::digit_value(held_reg);
    assign lo = ped_pkg::digit_value(item.in_byte);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        disc_next  = disc_reg;
        push       = 1'b0;
        cmd        = '0;
        if (accept)
        begin
            if (disc_reg)
            begin
                // The rest of a failed key produces nothing.
                if (item.in_last)
                begin
                    disc_next  = 1'b0;
                    phase_next = PH_PLAIN;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        if (item.in_last)
                        begin
                            push       = 1'b1;
                            cmd.two    = 1'b1;
                            cmd.r0     = '{out_byte: ped_pkg::PERCENT_CHAR,
                                           out_last: 1'b0, syntax_error: 1'b0};
                            cmd.r1     = '{out_byte: item.in_byte,
                                           out_last: 1'b1, syntax_error: 1'b0};
                            phase_next = PH_PLAIN;
                        end
                        else
                        begin
                            held_next  = item.in_byte;
                            phase_next = PH_DIG;
                        end
                    end
                    PH_DIG:
                    begin
                        phase_next = PH_PLAIN;
                        push       = 1'b1;
                        if (!hi.ok || !lo.ok)
                        begin
                            cmd.r0    = '{out_byte: 8'd0, out_last: 1'b1,
                                          syntax_error: 1'b1};
                            disc_next = !item.in_last;
                        end
                        else
                        begin
                            cmd.r0 = '{out_byte: {hi.val[3:0], 4'd0} | {2'd0, lo.val},
                                       out_last: item.in_last, syntax_error: 1'b0};
                        end
                    end
                    default:
                    begin
                        phase_next = PH_PLAIN;
                        if (item.in_byte == ped_pkg::PERCENT_CHAR && !item.in_last)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            push   = 1'b1;
                            cmd.r0 = '{out_byte: item.in_byte, out_last: item.in_last,
                                       syntax_error: 1'b0};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            held_reg  <= 8'd0;
            disc_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            disc_reg  <= disc_next;
        end
    end

endmodule

// ----- hw/rtl/ped_queue.sv -----
// Short queue of result entries between the front and back parts.
// Depends on ped_pkg.
module ped_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ped_pkg::ped_cmd_t   cmd,
    output logic                full,
    input  logic                pop,
    output ped_pkg::ped_qhead_t head
);

    ped_pkg::ped_cmd_t              mem_reg [ped_pkg::QDEPTH];
    logic [ped_pkg::QAW-1:0]        wr_reg, wr_next;
    logic [ped_pkg::QAW-1:0]        rd_reg, rd_next;
    logic [ped_pkg::QCW-1:0]        cnt_reg, cnt_next;

    assign full       = (cnt_reg == ped_pkg::QCW'(ped_pkg::QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue read while empty");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != ped_pkg::QCW'(ped_pkg::QDEPTH) && cnt_reg != '0) |->
            (wr_reg != rd_reg))
        else $error("queue count disagrees with pointers");

endmodule

// ----- hw/rtl/ped_back.sv -----
// Back part of the percent-escape decoder: drains queue entries and
// presents their results one per transfer through an output register.
// Depends on ped_pkg.
module ped_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ped_pkg::ped_qhead_t head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output ped_pkg::ped_out_t   result
);

    logic              valid_reg, valid_next;
    logic              half_reg, half_next;
    ped_pkg::ped_out_t out_reg, out_next;
    logic              load;

    // The output register may take a new result when it is empty or drained.
    assign load = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = head.valid;
            if (head.valid)
            begin
                if (head.cmd.two && !half_reg)
                begin
                    out_next  = head.cmd.r0;
                    half_next = 1'b1;
                end
                else
                begin
                    out_next  = half_reg ? head.cmd.r1 : head.cmd.r0;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

    a_half_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (head.valid && head.cmd.two))
        else $error("second result pending without a paired entry");

    a_half_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(half_reg) |-> valid_reg)
        else $error("second result pending with no first result shown");

    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> load)
        else $error("queue entry consumed while the output is stalled");

endmodule

// ----- test/ped_unescape_checker.sv -----
`timescale 1ns / 100ps
// Checker for the percent-escape decoder: watches both channels, predicts every
// decoded byte from the accepted input bytes and compares results in order.
// Depends on ped_pkg for the payload types and character constants.
module ped_unescape_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  ped_pkg::ped_in_t  item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  ped_pkg::ped_out_t result,
    output int                fail_count,
    output int                outstanding,
    output int                results_checked,
    output int                error_results
);
    import ped_pkg::*;

    typedef enum logic [1:0]
    {
        PH_PLAIN,
        PH_PERCENT,
        PH_FIRST_DIGIT,
        PH_SPARE
    } esc_phase_e;

    localparam int REPORT_LIMIT = 10;

    esc_phase_e phase;
    logic [7:0] first_digit;
    logic       skip_rest;
    ped_out_t   awaited_q[$];

    // Value of an escape digit, or -1 for anything that is not alphanumeric.
    function automatic int digit_worth(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            return int'(c) - int'(CHAR_0);
        end
        if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            return 10 + int'(c) - int'(CHAR_LA);
        end
        if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            return 10 + int'(c) - int'(CHAR_UA);
        end
        return -1;
    endfunction

    function automatic void add_expected(input logic [7:0] b, input logic l, input logic e);
        ped_out_t r;
        r.out_byte     = b;
        r.out_last     = l;
        r.syntax_error = e;
        awaited_q.push_back(r);
    endfunction

    task automatic decode_byte(input ped_in_t x);
        int hi;
        int lo;
        if (skip_rest)
        begin
            // The rest of a key with a bad escape is dropped up to its last byte.
            if (x.in_last)
            begin
                skip_rest = 1'b0;
                phase     = PH_PLAIN;
            end
        end
        else
        begin
            case (phase)
                PH_PERCENT:
                begin
                    if (x.in_last)
                    begin
                        add_expected(PERCENT_CHAR, 1'b0, 1'b0);
                        add_expected(x.in_byte, 1'b1, 1'b0);
                        phase = PH_PLAIN;
                    end
                    else
                    begin
                        first_digit = x.in_byte;
                        phase       = PH_FIRST_DIGIT;
                    end
                end
                PH_FIRST_DIGIT:
                begin
                    hi    = digit_worth(first_digit);
                    lo    = digit_worth(x.in_byte);
                    phase = PH_PLAIN;
                    if (hi < 0 || lo < 0)
                    begin
                        add_expected(8'h00, 1'b1, 1'b1);
                        skip_rest = !x.in_last;
                    end
                    else
                    begin
                        add_expected(8'((hi << 4) | lo), x.in_last, 1'b0);
                    end
                end
                default:
                begin
                    phase = PH_PLAIN;
                    if (x.in_byte == PERCENT_CHAR && !x.in_last)
                    begin
                        phase = PH_PERCENT;
                    end
                    else
                    begin
                        add_expected(x.in_byte, x.in_last, 1'b0);
                    end
                end
            endcase
            if (x.in_last)
            begin
                phase = PH_PLAIN;
            end
        end
    endtask

    task automatic check_result(input ped_out_t got);
        ped_out_t want;
        results_checked++;
        if (got.syntax_error === 1'b1)
        begin
            error_results++;
        end
        if (awaited_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected result byte %02h last %0b error %0b",
                         $realtime, got.out_byte, got.out_last, got.syntax_error);
            end
        end
        else
        begin
            want = awaited_q.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                got.syntax_error !== want.syntax_error)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("%0t: expected %02h/%0b/%0b (byte/last/error), got %02h/%0b/%0b",
                             $realtime, want.out_byte, want.out_last, want.syntax_error,
                             got.out_byte, got.out_last, got.syntax_error);
                end
            end
        end
    endtask

    // Results are checked before the same edge's input is decoded, since an
    // input transfer can never produce a result on its own edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_PLAIN;
            first_digit = 8'h00;
            skip_rest   = 1'b0;
            awaited_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_result(result);
            end
            if (item_valid && !item_stall)
            begin
                decode_byte(item);
            end
            outstanding = awaited_q.size();
        end
    end

endmodule

// ----- test/tb_percent_escape_decoder_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the percent-escape decoder: clock, reset, key stimulus and
// random idling on both channels. Depends on ped_pkg, the decoder RTL and
// ped_unescape_checker, which does all prediction and comparison.
module tb_percent_escape_decoder_top;
    import ped_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int DRAIN_EVERY    = 40;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_stall;
    ped_in_t  item         = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    ped_out_t result;

    int fail_count;
    int outstanding;
    int results_checked;
    int error_results;
    int idle_pct   = 23;
    int bytes_sent = 0;
    int keys_sent  = 0;
    int stuck_cycles;

    logic [7:0] key_q[$];

    percent_escape_decoder_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ped_unescape_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .error_results   (error_results)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < idle_pct);
    end

    function automatic logic [7:0] pick_digit();
        case ($urandom_range(2))
            0:       return CHAR_0 + 8'($urandom_range(9));
            1:       return CHAR_LA + 8'($urandom_range(25));
            default: return CHAR_UA + 8'($urandom_range(25));
        endcase
    endfunction

    // Bytes outside 0-9, a-z and A-Z, the upper half included.
    function automatic logic [7:0] pick_non_digit();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(8'h2f));
            1:       return 8'($urandom_range(8'h40, 8'h3a));
            2:       return 8'($urandom_range(8'h60, 8'h5b));
            default: return 8'($urandom_range(8'hff, 8'h7b));
        endcase
    endfunction

    // Mostly well-formed escapes and plain bytes, with some bad digits, stray
    // percent signs and escapes cut short by the end of the key.
    function automatic void build_key();
        int segs;
        int roll;
        key_q.delete();
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                key_q.push_back(8'($urandom_range(255)));
            end
            else if (roll < 85)
            begin
                key_q.push_back(PERCENT_CHAR);
                key_q.push_back(pick_digit());
                key_q.push_back(pick_digit());
            end
            else if (roll < 95)
            begin
                key_q.push_back(PERCENT_CHAR);
                case ($urandom_range(2))
                    0:
                    begin
                        key_q.push_back(pick_non_digit());
                        key_q.push_back(pick_digit());
                    end
                    1:
                    begin
                        key_q.push_back(pick_digit());
                        key_q.push_back(pick_non_digit());
                    end
                    default:
                    begin
                        key_q.push_back(pick_non_digit());
                        key_q.push_back(pick_non_digit());
                    end
                endcase
            end
            else
            begin
                key_q.push_back(PERCENT_CHAR);
            end
        end
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            key_q.push_back(PERCENT_CHAR);
        end
        else if (roll < 16)
        begin
            key_q.push_back(PERCENT_CHAR);
            key_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{in_byte: b, in_last: l};
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_key();
        for (int i = 0; i < key_q.size(); i++)
        begin
            send_byte(key_q[i], i == key_q.size() - 1);
        end
        keys_sent++;
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
        end
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme plain bytes.
        key_q = '{8'h00, 8'hff};
        send_key();
        // "%41" and "%zZ0": decimal and letter digits, wrap of 35 * 16 + 35.
        key_q = '{PERCENT_CHAR, 8'h34, 8'h31};
        send_key();
        key_q = '{PERCENT_CHAR, 8'h7a, 8'h5a, 8'h30};
        send_key();
        // Percent on the last byte, and percent plus one byte at key end.
        key_q = '{PERCENT_CHAR};
        send_key();
        key_q = '{PERCENT_CHAR, 8'h67};
        send_key();
        // Bad first digit mid-key: the rest of the key is dropped.
        key_q = '{PERCENT_CHAR, 8'h23, 8'h31, 8'h78, 8'h79};
        send_key();
        // Bad second digit in the upper half, on the last byte.
        key_q = '{PERCENT_CHAR, 8'h31, 8'h80};
        send_key();
        // Slash sits just below '0'; the byte after it is dropped.
        key_q = '{PERCENT_CHAR, 8'h39, 8'h2f, 8'h41};
        send_key();
        wait_for_drain();

        while (bytes_sent < ITEM_TARGET)
        begin
            idle_pct = (bytes_sent >= 500 && bytes_sent < 700) ? 0 : 23;
            if (keys_sent % DRAIN_EVERY == DRAIN_EVERY - 1)
            begin
                wait_for_drain();
            end
            build_key();
            send_key();
        end
        idle_pct = 23;

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d bytes in %0d keys; checked %0d results, %0d of them syntax errors.",
                 bytes_sent, keys_sent, results_checked, error_results);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d failures, %0d results never arrived", fail_count, outstanding);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
